// File: design/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix-to-postfix converter
// Holds the beat structs, the internal command format and the precedence
// function used by the classifier and the stack engine.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	typedef enum logic [1:0] {
		ST_OK,
		ST_CLOSE_NO_OPEN,
		ST_STACK_FULL,
		ST_OPEN_LEFT
	} status_t;

	typedef enum logic [2:0] {
		CMD_SKIP,
		CMD_LETTER,
		CMD_OPEN,
		CMD_CLOSE,
		CMD_OPER
	} cmd_kind_t;

	typedef enum logic {
		BK_RUN,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_expr;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       last_out;
		status_t    status;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
		logic [1:0] prec;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} front_req_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_PLUS || c == CH_MINUS) begin
			p = 2'd1;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			p = 2'd2;
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// File: design/infix_to_postfix_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: streaming infix-to-postfix converter
// Shunting-yard conversion of one infix character per input beat into
// postfix result beats, with bracket and stack overflow checking.
// ----------------------------------------------------------------------------
// Input beats are classified at once and placed in a four-entry command
// queue, so the input side takes one beat per cycle while the queue has
// room. The stack engine behind it handles a command that needs no pop
// (skip, letter, push) on its own, pops the stacked entries that a ')' or
// an operator removes one at a time, and, on the final character, empties
// the 32-entry operator stack one entry at a time and then closes the
// expression, carrying the closing status beat when one is due. That
// engine, which emits at most one result beat per cycle, sets the sustained
// rate; results leave through a single output register that can be refilled
// in the cycle it is taken.
module infix_to_postfix_converter_unit import itp_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire in_item_t  item,
	input  wire            item_valid,
	output logic           item_ready,
	output out_item_t      result,
	output logic           result_valid,
	input  wire            result_ready
);

	front_req_t req;
	logic       q_full;
	logic       head_valid;
	cmd_t       head;
	logic       deq;

	itp_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.q_full     (q_full),
		.req        (req)
	);

	itp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.full       (q_full),
		.pop        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	itp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.deq          (deq),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
`default_nettype wire

// File: design/itp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_front: input classifier
// Accepts input beats while the command queue has room and turns each
// character into a command for the stack engine.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
	input  wire in_item_t   item,
	input  wire             item_valid,
	output logic            item_ready,
	input  wire             q_full,
	output front_req_t      req
);

	logic [7:0] c;
	logic       is_space;
	logic       is_letter;

	assign c          = item.in_char;
	assign item_ready = !q_full;

	assign is_space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	assign is_letter = (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);

	always_comb begin
		req.push     = item_valid && !q_full;
		req.cmd.ch   = c;
		req.cmd.prec = prec_of(c);
		req.cmd.fin  = item.end_of_expr;
		if (is_space) begin
			req.cmd.kind = CMD_SKIP;
		end else if (is_letter) begin
			req.cmd.kind = CMD_LETTER;
		end else if (c == CH_OPEN) begin
			req.cmd.kind = CMD_OPEN;
		end else if (c == CH_CLOSE) begin
			req.cmd.kind = CMD_CLOSE;
		end else begin
			req.cmd.kind = CMD_OPER;
		end
	end

endmodule
`default_nettype wire

// File: design/itp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_queue: command queue
// Small first-in first-out buffer that decouples the classifier from the
// stack engine.
// ----------------------------------------------------------------------------
module itp_queue import itp_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire front_req_t req,
	output logic            full,
	input  wire             pop,
	output logic            head_valid,
	output cmd_t            head
);

	cmd_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (req.push) begin
			entry_q[wr_ptr_q] <= req.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (req.push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!req.push && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: design/itp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_back: operator stack engine
// Executes queued commands against the operator stack, at most one push or
// pop per cycle (an emit waits for a free result register), and holds it.
// ----------------------------------------------------------------------------
module itp_back import itp_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       head_valid,
	input  wire cmd_t head,
	output logic      deq,
	output out_item_t result,
	output logic      result_valid,
	input  wire       result_ready
);

	logic [7:0]       stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	back_state_t      state_q;
	back_state_t      state_d;
	logic             emitted_q;
	logic             dropped_q;
	logic             result_valid_q;
	out_item_t        result_q;

	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_dec2;
	logic [IDX_W-1:0] top_idx;
	logic [7:0]       top;
	logic [7:0]       below;
	logic             empty;
	logic             full;
	logic             slot_free;
	logic             emit;
	out_item_t        emit_item;
	logic             push;
	logic             pop;
	logic             set_drop;
	logic             item_done;

	assign cnt_dec   = count_q - CNT_W'(1);
	assign cnt_dec2  = count_q - CNT_W'(2);
	assign top_idx   = cnt_dec[IDX_W-1:0];
	assign top       = stack_q[top_idx];
	assign below     = stack_q[cnt_dec2[IDX_W-1:0]];
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign slot_free = !result_valid_q || result_ready;

	always_comb begin
		state_d              = state_q;
		emit                 = 1'b0;
		emit_item.out_char   = 8'd0;
		emit_item.char_valid = 1'b0;
		emit_item.last_out   = 1'b0;
		emit_item.status     = ST_OK;
		push                 = 1'b0;
		pop                  = 1'b0;
		deq                  = 1'b0;
		set_drop             = 1'b0;
		item_done            = 1'b0;
		case (state_q)
			BK_RUN: begin
				if (head_valid) begin
					case (head.kind)
						CMD_SKIP: begin
							deq = 1'b1;
						end
						CMD_LETTER: begin
							if (slot_free) begin
								emit                 = 1'b1;
								emit_item.out_char   = head.ch;
								emit_item.char_valid = 1'b1;
								// Final beat only if the flush will find nothing.
								emit_item.last_out   = head.fin && empty;
								deq                  = 1'b1;
							end
						end
						CMD_OPEN: begin
							if (!full) begin
								push = 1'b1;
								deq  = 1'b1;
							end else if (slot_free) begin
								emit             = 1'b1;
								emit_item.status = ST_STACK_FULL;
								deq              = 1'b1;
							end
						end
						CMD_CLOSE: begin
							if (empty) begin
								if (slot_free) begin
									emit               = 1'b1;
									emit_item.status   = ST_CLOSE_NO_OPEN;
									emit_item.last_out = head.fin;
									deq                = 1'b1;
								end
							end else if (top == CH_OPEN) begin
								pop = 1'b1;
								deq = 1'b1;
							end else if (slot_free) begin
								emit                 = 1'b1;
								emit_item.out_char   = top;
								emit_item.char_valid = 1'b1;
								// On the final character, the operator sitting on the
								// bottom bracket is the last beat of the expression.
								emit_item.last_out   = head.fin &&
									(count_q == CNT_W'(2)) && (below == CH_OPEN);
								pop                  = 1'b1;
							end
						end
						default: begin
							if (!empty && head.prec <= prec_of(top)) begin
								if (slot_free) begin
									emit                 = 1'b1;
									emit_item.out_char   = top;
									emit_item.char_valid = 1'b1;
									pop                  = 1'b1;
								end
							end else if (!full) begin
								push = 1'b1;
								deq  = 1'b1;
							end else if (slot_free) begin
								emit             = 1'b1;
								emit_item.status = ST_STACK_FULL;
								deq              = 1'b1;
							end
						end
					endcase
				end
				if (deq) begin
					if (head.fin) begin
						state_d = BK_FLUSH;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			BK_FLUSH: begin
				if (!empty) begin
					if (top == CH_OPEN) begin
						pop      = 1'b1;
						set_drop = 1'b1;
					end else if (slot_free) begin
						emit                 = 1'b1;
						emit_item.out_char   = top;
						emit_item.char_valid = 1'b1;
						// The last stacked operator closes the expression unless
						// a dropped bracket still has to be reported.
						emit_item.last_out   = (count_q == CNT_W'(1)) && !dropped_q;
						pop                  = 1'b1;
					end
				end else if (dropped_q || !emitted_q) begin
					if (slot_free) begin
						emit               = 1'b1;
						emit_item.last_out = 1'b1;
						emit_item.status   = dropped_q ? ST_OPEN_LEFT : ST_OK;
						item_done          = 1'b1;
						state_d            = BK_RUN;
					end
				end else begin
					item_done = 1'b1;
					state_d   = BK_RUN;
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[count_q[IDX_W-1:0]] <= head.ch;
		end
		if (emit) begin
			result_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_RUN;
			count_q        <= '0;
			emitted_q      <= 1'b0;
			dropped_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop) begin
				count_q <= cnt_dec;
			end
			if (item_done) begin
				emitted_q <= 1'b0;
				dropped_q <= 1'b0;
			end else begin
				emitted_q <= emitted_q || emit;
				dropped_q <= dropped_q || set_drop;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

// File: design/itp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_checker: port-level checks for the infix-to-postfix converter
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module itp_checker import itp_pkg::*; (
	input wire            clk,
	input wire            arst_n,
	input wire in_item_t  item,
	input wire            item_valid,
	input wire            item_ready,
	input wire out_item_t result,
	input wire            result_valid,
	input wire            result_ready
);

	// A stalled input beat must hold still.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input beat changed while stalled");

	// A stalled result beat must hold still.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// A beat that carries a character always reports a clean status.
	a_char_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.char_valid |-> result.status == ST_OK)
		else $error("character beat with error status");

	// Status-only beats carry a zero character.
	a_nochar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.char_valid |-> result.out_char == 8'd0)
		else $error("status beat with nonzero character");

	// The unclosed bracket report is always the final beat of an expression.
	a_open_left_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OPEN_LEFT |-> result.last_out)
		else $error("open bracket report not marked last");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item         (item),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready)
);
`default_nettype wire

// File: test/infix_to_postfix_converter_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_tb: testbench for the infix-to-postfix unit
// Drives infix characters through the input channel, predicts the postfix
// beats with a shunting-yard model of its own, and checks every result beat
// in order. Covers bracket errors, stack overflow and back-pressure stalls.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_tb;
	import itp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 50;
	localparam int RANDOM_ITEMS = 225;

	class postfix_scoreboard;
		logic [7:0] op_stack [STACK_DEPTH];
		int op_depth;
		out_item_t postfix_due[$];
		int mismatches;

		function new();
			op_depth = 0;
			mismatches = 0;
		endfunction

		function int rank(logic [7:0] c);
			if (c == CH_PLUS || c == CH_MINUS) begin
				return 1;
			end
			if (c == CH_STAR || c == CH_SLASH) begin
				return 2;
			end
			return 0;
		endfunction

		function void add_beat(logic [7:0] c, logic valid, status_t st);
			out_item_t b;
			b = '{out_char: c, char_valid: valid, last_out: 1'b0, status: st};
			postfix_due.push_back(b);
		endfunction

		// A push onto a full stack is lost and flagged instead.
		function void push_op(logic [7:0] c);
			if (op_depth >= STACK_DEPTH) begin
				add_beat(8'h00, 1'b0, ST_STACK_FULL);
			end else begin
				op_stack[op_depth] = c;
				op_depth++;
			end
		endfunction

		function void take_infix_char(in_item_t beat);
			logic [7:0] c;
			logic [7:0] top;
			bit found;
			bit dropped_open;
			int n0;
			c = beat.in_char;
			n0 = postfix_due.size();
			if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
				add_beat(c, 1'b1, ST_OK);
			end else if (c == CH_OPEN) begin
				push_op(c);
			end else if (c == CH_CLOSE) begin
				found = 1'b0;
				while (op_depth > 0 && !found) begin
					op_depth--;
					top = op_stack[op_depth];
					if (top == CH_OPEN) begin
						found = 1'b1;
					end else begin
						add_beat(top, 1'b1, ST_OK);
					end
				end
				if (!found) begin
					add_beat(8'h00, 1'b0, ST_CLOSE_NO_OPEN);
				end
			end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
				while (op_depth > 0 && rank(c) <= rank(op_stack[op_depth - 1])) begin
					op_depth--;
					add_beat(op_stack[op_depth], 1'b1, ST_OK);
				end
				push_op(c);
			end
			if (beat.end_of_expr) begin
				dropped_open = 1'b0;
				while (op_depth > 0) begin
					op_depth--;
					if (op_stack[op_depth] == CH_OPEN) begin
						dropped_open = 1'b1;
					end else begin
						add_beat(op_stack[op_depth], 1'b1, ST_OK);
					end
				end
				if (dropped_open) begin
					add_beat(8'h00, 1'b0, ST_OPEN_LEFT);
				end else if (postfix_due.size() == n0) begin
					add_beat(8'h00, 1'b0, ST_OK);
				end
				postfix_due[postfix_due.size() - 1].last_out = 1'b1;
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_postfix_beat(out_item_t got);
			out_item_t want;
			if (postfix_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat %h", got));
				return;
			end
			want = postfix_due.pop_front();
			if (got.out_char !== want.out_char) begin
				report_mismatch($sformatf("out_char %h, expected %h",
					got.out_char, want.out_char));
			end
			if (got.char_valid !== want.char_valid) begin
				report_mismatch($sformatf("char_valid %b, expected %b",
					got.char_valid, want.char_valid));
			end
			if (got.last_out !== want.last_out) begin
				report_mismatch($sformatf("last_out %b, expected %b",
					got.last_out, want.last_out));
			end
			if (got.status !== want.status) begin
				report_mismatch($sformatf("status %0d, expected %0d",
					got.status, want.status));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_item_t item = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	out_item_t result;
	logic result_valid;
	logic result_ready = 1'b0;

	postfix_scoreboard sb = new();

	bit sender_calm = 1'b0;
	int results_seen = 0;
	int quiet_cycles = 0;
	logic [7:0] expr_q[$];

	infix_to_postfix_converter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.result(result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_postfix_beat(result);
			results_seen++;
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver: random stalls, one long hold-off to back the block up, and a
	// calm window with no stalls.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 80) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (results_seen >= 110 && results_seen < 170) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic send_char(input logic [7:0] ch, input logic fin);
		while (!sender_calm && $urandom_range(99) < 22) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= '{in_char: ch, end_of_expr: fin};
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		sb.take_infix_char('{in_char: ch, end_of_expr: fin});
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		while (sb.postfix_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] base;
		base = ($urandom_range(1) != 0) ? CH_UC_A : CH_LC_A;
		return base + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] pick_oper();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic void maybe_blank();
		if ($urandom_range(9) == 0) begin
			expr_q.push_back(pick_blank());
		end
	endfunction

	function automatic void add_operand(int lvl);
		maybe_blank();
		if (lvl < 3 && $urandom_range(3) == 0) begin
			expr_q.push_back(CH_OPEN);
			add_sum(lvl + 1);
			expr_q.push_back(CH_CLOSE);
		end else begin
			expr_q.push_back(pick_letter());
		end
		maybe_blank();
	endfunction

	function automatic void add_sum(int lvl);
		int terms;
		terms = $urandom_range(1, 4);
		add_operand(lvl);
		for (int i = 1; i < terms; i++) begin
			expr_q.push_back(pick_oper());
			add_operand(lvl);
		end
	endfunction

	// Deep nesting that can run the operator stack past its capacity.
	function automatic void build_deep();
		int n;
		n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
		repeat (n) expr_q.push_back(CH_OPEN);
		expr_q.push_back(pick_letter());
		expr_q.push_back(pick_oper());
		expr_q.push_back(pick_letter());
		repeat ($urandom_range(3)) expr_q.push_back(CH_CLOSE);
	endfunction

	function automatic void break_expr();
		int pos;
		pos = $urandom_range(expr_q.size() - 1);
		case ($urandom_range(3))
			0: expr_q.insert(pos, CH_CLOSE);
			1: expr_q.insert(pos, CH_OPEN);
			2: expr_q.insert(pos, 8'($urandom_range(255)));
			default: begin
				if (expr_q.size() > 1) begin
					expr_q.delete(pos);
				end
			end
		endcase
	endfunction

	initial begin
		int sent;
		int kind;
		int exprs;
		logic [7:0] ch;
		sent = 0;
		exprs = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A*(z-Z)/a : three operators, both letter extremes, a matched bracket.
		send_char(CH_UC_A, 1'b0);
		send_char(CH_STAR, 1'b0);
		send_char(CH_OPEN, 1'b0);
		send_char(CH_LC_Z, 1'b0);
		send_char(CH_MINUS, 1'b0);
		send_char(CH_UC_Z, 1'b0);
		send_char(CH_CLOSE, 1'b0);
		send_char(CH_SLASH, 1'b0);
		send_char(CH_LC_A, 1'b1);
		// Close on an empty stack.
		send_char(CH_CLOSE, 1'b1);
		// c+d) : close that pops an operator and never finds its bracket.
		send_char(8'h63, 1'b0);
		send_char(CH_PLUS, 1'b0);
		send_char(8'h64, 1'b0);
		send_char(CH_CLOSE, 1'b1);
		// Open bracket still stacked at the end.
		send_char(CH_OPEN, 1'b0);
		send_char(CH_PLUS, 1'b0);
		send_char(8'h62, 1'b1);
		// A lone blank on the final beat still closes the expression.
		send_char(CH_SPACE, 1'b1);
		// Other characters pop a stacked bracket and each other.
		send_char(CH_TAB, 1'b0);
		send_char(CH_OPEN, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h0B, 1'b0);
		send_char(8'h71, 1'b1);

		// The sender waits here until the block has emptied.
		wait_for_drain();
		@(negedge clk);

		while (sent < RANDOM_ITEMS) begin
			expr_q.delete();
			kind = $urandom_range(99);
			if (exprs == 0 || exprs == 12 || (kind < 3)) begin
				build_deep();
			end else if (kind < 18) begin
				repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(255)));
			end else if (kind < 33) begin
				add_sum(0);
				break_expr();
			end else begin
				add_sum(0);
			end
			exprs++;
			for (int i = 0; i < expr_q.size(); i++) begin
				ch = expr_q[i];
				sender_calm = (sent >= 120 && sent < 180);
				send_char(ch, i == expr_q.size() - 1);
				sent++;
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
